@@ hdl/tmh_pkg.sv @@
// ----------------------------------------------------------------------------
// tmh_pkg: shared types, constants and functions for the MLP head
// Store layout constants, request/result structs, tanh table.
// ----------------------------------------------------------------------------
`default_nettype none
package tmh_pkg;

  localparam int Hidden = 8;
  localparam int StoreDepth = 6 * Hidden + 2;
  localparam int B1Base = 3 * Hidden;
  localparam int W2Base = 4 * Hidden;
  localparam int B2Base = 6 * Hidden;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef struct packed {
    logic               func;
    logic [5:0]         weight_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] current;
    logic [15:0]        charge_state;
    logic signed [15:0] temperature;
  } req_t;

  typedef struct packed {
    logic signed [15:0] correction_a;
    logic signed [15:0] correction_b;
  } rsp_t;

  typedef logic signed [15:0] word_t;
  typedef word_t weights_t [StoreDepth];
  typedef word_t hid_t [Hidden];
  typedef logic signed [15:0] xvec_t [3];

  // tanh(k/8), k = 0..32, Q1.15
  function automatic logic [14:0] tanh_tab(input logic [5:0] k);
    logic [14:0] v;
    case (k)
      6'd0: v = 15'd0;      6'd1: v = 15'd4075;   6'd2: v = 15'd8025;
      6'd3: v = 15'd11743;  6'd4: v = 15'd15143;  6'd5: v = 15'd18173;
      6'd6: v = 15'd20813;  6'd7: v = 15'd23066;  6'd8: v = 15'd24956;
      6'd9: v = 15'd26519;  6'd10: v = 15'd27797; 6'd11: v = 15'd28830;
      6'd12: v = 15'd29660; 6'd13: v = 15'd30323; 6'd14: v = 15'd30847;
      6'd15: v = 15'd31262; 6'd16: v = 15'd31589; 6'd17: v = 15'd31846;
      6'd18: v = 15'd32048; 6'd19: v = 15'd32206; 6'd20: v = 15'd32329;
      6'd21: v = 15'd32428; 6'd22: v = 15'd32501; 6'd23: v = 15'd32561;
      6'd24: v = 15'd32606; 6'd25: v = 15'd32642; 6'd26: v = 15'd32670;
      6'd27: v = 15'd32691; 6'd28: v = 15'd32708; 6'd29: v = 15'd32722;
      6'd30: v = 15'd32732; 6'd31: v = 15'd32740;
      default: v = 15'd32746;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sd32767;
    if (v < -48'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/tmh_scale.sv @@
// ----------------------------------------------------------------------------
// tmh_scale: sensor inputs to Q1.15
// Two-stage: reciprocal multiply, then floor correction and saturate.
// ----------------------------------------------------------------------------
`default_nettype none
module tmh_scale (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [15:0]  current,
  input  wire logic [15:0]         charge_state,
  input  wire logic signed [15:0]  temperature,
  output tmh_pkg::xvec_t           x
);
  // n0 = cur*32768+5000, n2 = (t+2000)*32768+3500; q = floor(n/d)
  logic signed [32:0] n0, n2;
  logic signed [32:0] n0_r, n2_r;
  logic signed [32:0] q0e, q2e;
  logic signed [32:0] q0_r, q2_r;
  logic [15:0] cs_r;
  logic signed [32:0] q0, q2;
  logic signed [32:0] r0, r2;

  assign n0 = 33'(current) * 33'sd32768 + 33'sd5000;
  assign n2 = (33'(temperature) + 33'sd2000) * 33'sd32768 + 33'sd3500;

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r <= n0;
      n2_r <= n2;
      cs_r <= charge_state;
      // Estimate via reciprocal; within one of the floor
      q0_r <= 33'((67'(n0) * 67'sd14073748835) >>> 47);
      q2_r <= 33'((67'(n2) * 67'sd20105355479) >>> 47);
    end
  end

  always_comb begin
    r0 = n0_r - q0_r * 33'sd10000;
    r2 = n2_r - q2_r * 33'sd7000;
    q0 = q0_r;
    q2 = q2_r;
    if (r0 < 0) q0 = q0_r - 33'sd1;
    else if (r0 >= 33'sd10000) q0 = q0_r + 33'sd1;
    if (r2 < 0) q2 = q2_r - 33'sd1;
    else if (r2 >= 33'sd7000) q2 = q2_r + 33'sd1;
    q0e = q0;
    q2e = q2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= tmh_pkg::sat16(48'(q0e));
      x[2] <= tmh_pkg::sat16(48'(q2e));
      x[1] <= cs_r[15] ? 16'sd32767 : $signed(cs_r);
    end
  end
endmodule
`default_nettype wire

@@ hdl/tmh_tanh.sv @@
// ----------------------------------------------------------------------------
// tmh_tanh: piecewise-linear odd tanh, Q.12 in, Q1.15 out (combinational)
// ----------------------------------------------------------------------------
`default_nettype none
module tmh_tanh (
  input  wire logic signed [20:0] u,
  output logic signed [15:0]      h
);
  logic [20:0] m;
  logic [5:0]  k;
  logic [8:0]  f;
  logic [14:0] t0, t1;
  logic [25:0] prod;
  logic [15:0] mag;

  always_comb begin
    m = u[20] ? 21'(-u) : 21'(u);
    k = {1'b0, m[13:9]};
    f = m[8:0];
    t0 = tmh_pkg::tanh_tab(k);
    t1 = tmh_pkg::tanh_tab(k + 6'd1);
    prod = 26'(t1 - t0) * 26'(f) + 26'd256;
    if (m >= 21'd16384) mag = 16'(tmh_pkg::tanh_tab(6'd32));
    else mag = 16'(t0) + 16'(prod >> 9);
    h = u[20] ? -$signed(mag) : $signed(mag);
  end
endmodule
`default_nettype wire

@@ hdl/tmh_layer.sv @@
// ----------------------------------------------------------------------------
// tmh_layer: hidden layer (dot products, registered, then tanh) and output
// layer (tanh outputs registered, then products, sum, round, saturate).
// ----------------------------------------------------------------------------
`default_nettype none
module tmh_layer (
  input  wire logic              clk,
  input  wire logic [1:0]        en,
  input  wire tmh_pkg::xvec_t    x,
  input  wire tmh_pkg::weights_t w,
  output tmh_pkg::rsp_t          rsp
);
  localparam int H = tmh_pkg::Hidden;
  logic signed [35:0] acc [H];
  logic signed [15:0] h [H];
  tmh_pkg::hid_t hr;
  logic signed [31:0] pr [2][H];
  logic signed [39:0] z [2];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < H; i++) begin
        acc[i] <= 36'(w[tmh_pkg::B1Base + i]) * 36'sd32768
                + 36'(w[3*i]) * 36'(x[0]) + 36'(w[3*i+1]) * 36'(x[1])
                + 36'(w[3*i+2]) * 36'(x[2]);
      end
    end
  end

  for (genvar i = 0; i < H; i++) begin : g_act
    tmh_tanh u_tanh (.u(21'((acc[i] + 36'sd16384) >>> 15)), .h(h[i]));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < H; i++) hr[i] <= h[i];
    end
  end

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      for (int i = 0; i < H; i++)
        pr[o][i] = 32'(w[tmh_pkg::W2Base + o*H + i]) * 32'(hr[i]);
      z[o] = 40'(w[tmh_pkg::B2Base + o]) * 40'sd32768 + 40'sd16384;
      for (int i = 0; i < H; i++) z[o] = z[o] + 40'(pr[o][i]);
    end
    rsp.correction_a = tmh_pkg::sat16(48'(z[0] >>> 15));
    rsp.correction_b = tmh_pkg::sat16(48'(z[1] >>> 15));
  end
endmodule
`default_nettype wire

@@ hdl/tanh_mlp_head_3x8x2.sv @@
// ----------------------------------------------------------------------------
// tanh_mlp_head_3x8x2: 3-8-2 perceptron head with tanh hidden units
// Weight loads and evaluations share one request channel; pipelined eval.
// ----------------------------------------------------------------------------
//  channel | signals                           | payload
//  --------+-----------------------------------+---------------
//  request | req_valid, req_ready, req         | tmh_pkg::req_t
//  result  | rsp_valid, rsp_ready, rsp         | tmh_pkg::rsp_t
//
// One request per cycle unless a stalled result holds the pipe. An evaluation
// passes five register stages (two scaling, hidden sums, tanh, output sums).
// Weights live in flip-flops written by load requests (no result). Reset
// clears valid bits only. A stall on the result freezes the whole pipe; ready
// is the output stage being empty or taken.
// ----------------------------------------------------------------------------
`default_nettype none
module tanh_mlp_head_3x8x2 (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire tmh_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output tmh_pkg::rsp_t      rsp
);
  tmh_pkg::weights_t w;
  tmh_pkg::xvec_t    x;
  tmh_pkg::rsp_t     res;
  logic [3:0] v;     // eval valid through scale1, scale2, hidden, tanh
  logic adv;

  // load delay line; a weight must not reach an evaluation accepted earlier
  logic [2:0]     ld_v;
  logic [5:0]     ld_idx [3];
  tmh_pkg::word_t ld_val [3];

  assign adv = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_v <= '0;
    end else if (adv) begin
      ld_v <= {ld_v[1:0], req_valid && req.func == tmh_pkg::FUNC_LOAD};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ld_idx[0] <= req.weight_index;
      ld_val[0] <= req.weight_value;
      ld_idx[1] <= ld_idx[0];
      ld_val[1] <= ld_val[0];
      ld_idx[2] <= ld_idx[1];
      ld_val[2] <= ld_val[1];
    end
  end

  // weight store: first-layer words are written from load stage 0, second-layer
  // words from stage 2, in step with where the hidden sums and the output sums
  // read the store, so order matches the request stream
  always_ff @(posedge clk) begin
    if (adv) begin
      if (ld_v[0] && 32'(ld_idx[0]) < tmh_pkg::W2Base)
        w[ld_idx[0]] <= ld_val[0];
      if (ld_v[2] && 32'(ld_idx[2]) >= tmh_pkg::W2Base
          && 32'(ld_idx[2]) < tmh_pkg::StoreDepth)
        w[ld_idx[2]] <= ld_val[2];
    end
  end

  tmh_scale u_scale (
    .clk(clk), .en(adv), .current(req.current),
    .charge_state(req.charge_state), .temperature(req.temperature), .x(x)
  );

  tmh_layer u_layer (.clk(clk), .en({adv, adv}), .x(x), .w(w), .rsp(res));

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      v <= {v[2:0], req_valid && req.func == tmh_pkg::FUNC_EVAL};
      rsp_valid <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) rsp <= res;
  end
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for tanh_mlp_head_3x8x2
// Loads every weight slot, then runs directed corner cases and random
// load/evaluate traffic under several idle/stall phases. A scoreboard model
// predicts each evaluation result and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none

// Model of the network plus in-order store of predicted results.
class mlp_scoreboard;
  localparam int TanhTab[33] = '{
    0, 4075, 8025, 11743, 15143, 18173, 20813, 23066,
    24956, 26519, 27797, 28830, 29660, 30323, 30847, 31262,
    31589, 31846, 32048, 32206, 32329, 32428, 32501, 32561,
    32606, 32642, 32670, 32691, 32708, 32722, 32732, 32740,
    32746};

  tmh_pkg::word_t weights[tmh_pkg::StoreDepth];
  tmh_pkg::rsp_t  predicted_q[$];
  int             errors;

  function longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function longint tanh_pwl(longint u);
    longint m, h, k, f;
    m = (u < 0) ? -u : u;
    if (m >= 16384) h = TanhTab[32];
    else begin
      k = m >> 9;
      f = m & 511;
      h = TanhTab[k] + (((TanhTab[k + 1] - TanhTab[k]) * f + 256) >>> 9);
    end
    return (u < 0) ? -h : h;
  endfunction

  function tmh_pkg::rsp_t evaluate(tmh_pkg::req_t r);
    longint x[3], hid[tmh_pkg::Hidden], acc, outv[2];
    tmh_pkg::rsp_t res;
    x[0] = clip16(floor_div(longint'(r.current) * 32768 + 5000, 10000));
    x[1] = clip16(longint'(r.charge_state));
    x[2] = clip16(floor_div((longint'(r.temperature) + 2000) * 32768 + 3500, 7000));
    for (int i = 0; i < tmh_pkg::Hidden; i++) begin
      acc = longint'(weights[tmh_pkg::B1Base + i]) * 32768;
      for (int k = 0; k < 3; k++) acc += longint'(weights[3 * i + k]) * x[k];
      hid[i] = tanh_pwl(floor_div(acc + 16384, 32768));
    end
    for (int o = 0; o < 2; o++) begin
      acc = longint'(weights[tmh_pkg::B2Base + o]) * 32768;
      for (int i = 0; i < tmh_pkg::Hidden; i++)
        acc += longint'(weights[tmh_pkg::W2Base + o * tmh_pkg::Hidden + i]) * hid[i];
      outv[o] = clip16(floor_div(acc + 16384, 32768));
    end
    res.correction_a = outv[0][15:0];
    res.correction_b = outv[1][15:0];
    return res;
  endfunction

  // accepted request: loads update the store, evaluations queue a result
  function void note_request(tmh_pkg::req_t r);
    if (r.func == tmh_pkg::FUNC_LOAD) begin
      if (r.weight_index < tmh_pkg::StoreDepth) weights[r.weight_index] = r.weight_value;
    end else predicted_q.push_back(evaluate(r));
  endfunction

  function void check_result(tmh_pkg::rsp_t r);
    tmh_pkg::rsp_t e;
    if (predicted_q.size() == 0) begin
      $display("%0t: unexpected result a=%0d b=%0d", $time, r.correction_a, r.correction_b);
      errors++;
      return;
    end
    e = predicted_q.pop_front();
    if (r.correction_a !== e.correction_a) begin
      $display("%0t: correction_a exp %0d act %0d", $time, e.correction_a, r.correction_a);
      errors++;
    end
    if (r.correction_b !== e.correction_b) begin
      $display("%0t: correction_b exp %0d act %0d", $time, e.correction_b, r.correction_b);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  tmh_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  tmh_pkg::rsp_t rsp;

  mlp_scoreboard sb = new();

  // idle/stall knobs, percent per cycle
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;   // asks the receiver for a long hold-off

  tanh_mlp_head_3x8x2 u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // generous limit on simulation time for a correct run
  initial begin
    #5ms;
    $display("tanh_mlp_head_3x8x2 test failed");
    $finish;
  end

  // result side: check on handshake, then pick next ready
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one request through the handshake; gaps come first so valid stays
  // high between back-to-back requests
  task automatic send_request(tmh_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic send_load(int idx, logic signed [15:0] val);
    tmh_pkg::req_t r;
    r = '0;
    r.func = tmh_pkg::FUNC_LOAD;
    r.weight_index = idx[5:0];
    r.weight_value = val;
    r.current = 16'($urandom());
    r.charge_state = 16'($urandom());
    r.temperature = 16'($urandom());
    send_request(r);
  endtask

  task automatic send_eval(logic signed [15:0] cur, logic [15:0] soc,
                           logic signed [15:0] temp);
    tmh_pkg::req_t r;
    r.func = tmh_pkg::FUNC_EVAL;
    r.weight_index = 6'($urandom());
    r.weight_value = 16'($urandom());
    r.current = cur;
    r.charge_state = soc;
    r.temperature = temp;
    send_request(r);
  endtask

  // weights: mostly modest so tanh stays in its linear/knee range
  function automatic logic signed [15:0] pick_weight();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return 16'($urandom());
      default: return 16'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_sensor();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return 16'($signed($urandom_range(12000)) - 6000);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_traffic(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 25) send_load($urandom_range(tmh_pkg::StoreDepth - 1), pick_weight());
      else if (sel < 29) send_load($urandom_range(63, tmh_pkg::StoreDepth), 16'($urandom()));
      else send_eval(pick_sensor(),
                     ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(32768)),
                     pick_sensor());
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.predicted_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every slot written before any evaluation
    for (int i = 0; i < tmh_pkg::StoreDepth; i++) send_load(i, pick_weight());

    // directed: sensor extremes, full charge and beyond, ignored slots
    send_eval(16'sh7FFF, 16'd32768, 16'sh7FFF);
    send_eval(16'sh8000, 16'd0, 16'sh8000);
    send_eval(16'sd0, 16'hFFFF, -16'sd2000);
    send_eval(16'sd10000, 16'd32767, 16'sd5000);
    send_eval(-16'sd10000, 16'd16384, 16'sd0);
    send_load(tmh_pkg::StoreDepth, 16'sh7FFF);
    send_load(63, 16'sh8000);
    send_eval(16'sd1, 16'd1, 16'sd1);
    send_load(tmh_pkg::B1Base, 16'sh7FFF);     // saturating bias: tanh clamp
    send_load(tmh_pkg::B2Base, 16'sh7FFF);     // output saturation high
    send_load(tmh_pkg::B2Base + 1, 16'sh8000); // output saturation low
    send_eval(16'sd500, 16'd20000, 16'sd2500);
    send_eval(-16'sd3000, 16'd100, -16'sd1000);
    send_load(tmh_pkg::B1Base, 16'sd0);
    send_load(tmh_pkg::B2Base, 16'sd0);
    send_load(tmh_pkg::B2Base + 1, 16'sd0);
    send_eval(16'sd250, 16'd8000, 16'sd1500);

    // long receiver hold-off while requests keep coming
    hold_request = 1'b1;
    random_traffic(150);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      random_traffic(410);
    end

    drain();
    if (sb.errors == 0) $display("tanh_mlp_head_3x8x2 test passed");
    else $display("tanh_mlp_head_3x8x2 test failed");
    $finish;
  end
endmodule
`default_nettype wire
